>>> hdl/kmps_pkg.sv
// Package with shared types and constants for the keyboard matrix port scanner.
package kmps_pkg;

    // Matrix geometry
    localparam int SCAN_LINES  = 12;
    localparam int SENSE_LINES = 6;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 3;

    // Port masks
    localparam logic [7:0] SENSE_FIELD_MASK = 8'hFC;
    localparam logic [7:0] COLOR_MASK       = 8'hD0;
    localparam logic [7:0] SOUND_BIT_MASK   = 8'h20;
    localparam logic [7:0] TAPE_BIT_MASK    = 8'h80;
    localparam logic [11:0] SCAN_HIGH_MASK  = 12'hF00;
    localparam logic [7:0] TAPE_IN_BIT      = 8'h01;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_A_INPUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_B_INPUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_C_LOW_INPUT = 2'd2;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_KEY     = 3'd0,
        OP_SHIFT   = 3'd1,
        OP_WRITE_A = 3'd2,
        OP_WRITE_B = 3'd3,
        OP_WRITE_C = 3'd4,
        OP_READ_A  = 3'd5,
        OP_READ_B  = 3'd6,
        OP_READ_C  = 3'd7
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ROW_W-1:0] key_row;
        logic [COL_W-1:0] key_column;
        logic             pressed;
        logic [7:0]       write_data;
        logic             tape_level;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       sound_gate;
        logic       tape_out;
        logic [7:0] color_value;
        logic       port_c_written;
    } result_t;

    // Key store update from the processing stage
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             pressed;
    } key_update_t;

endpackage

>>> hdl/kmps_matrix.sv
// Key matrix store with forward and reverse scan logic.
module kmps_matrix
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  kmps_pkg::key_update_t               key_update,
    input  logic [kmps_pkg::SCAN_LINES-1:0]     scan_mask,
    input  logic [kmps_pkg::SENSE_LINES-1:0]    sense_mask,
    output logic [kmps_pkg::SENSE_LINES-1:0]    rows_sensed,
    output logic [kmps_pkg::SCAN_LINES-1:0]     cols_sensed
);

    logic [kmps_pkg::SENSE_LINES-1:0] key_bits_reg [kmps_pkg::SCAN_LINES];
    logic                             key_in_range;

    assign key_in_range = (key_update.row < kmps_pkg::ROW_W'(kmps_pkg::SCAN_LINES))
                       && (key_update.col < kmps_pkg::COL_W'(kmps_pkg::SENSE_LINES));

    // Set or clear one key bit; drop keys outside the matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < kmps_pkg::SCAN_LINES; r++)
            begin
                key_bits_reg[r] <= '0;
            end
        end
        else if (key_update.en && key_in_range)
        begin
            key_bits_reg[key_update.row][key_update.col] <= key_update.pressed;
        end
    end

    // OR the selected rows, and the selected columns across all rows
    always_comb
    begin
        logic [kmps_pkg::SENSE_LINES-1:0] row_acc;
        logic [kmps_pkg::SCAN_LINES-1:0]  col_acc;
        row_acc = '0;
        col_acc = '0;
        for (int r = 0; r < kmps_pkg::SCAN_LINES; r++)
        begin
            if (!scan_mask[r])
            begin
                row_acc = row_acc | key_bits_reg[r];
            end
            col_acc[r] = |(key_bits_reg[r] & ~sense_mask);
        end
        rows_sensed = ~row_acc;
        cols_sensed = ~col_acc;
    end

endmodule

>>> hdl/keyboard_matrix_port_scanner_unit.sv
// Top level of the keyboard matrix port scanner.
//
// Accepts one request per clock (busy stays low) and returns exactly one result per
// request. The request is registered at the accepting edge. The port logic then updates
// the matrix, the masks and port C, and loads the result register at the next edge. The
// result shows with result_valid in the cycle after that edge and is taken at the
// edge that ends that cycle. The longest path is the OR over twelve rows of the
// key matrix. The receiver cannot stall; results must be taken as they appear.
// Configuration writes are ready except in a cycle where a registered request is being
// processed, and belong in idle periods.
module keyboard_matrix_port_scanner_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  kmps_pkg::request_t               request,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kmps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data,
    output logic                             result_valid,
    output kmps_pkg::result_t                result
);

    logic                   req_valid_reg;
    kmps_pkg::request_t     req_reg;
    logic [11:0]            scan_mask_reg, scan_mask_next;
    logic [5:0]             sense_mask_reg, sense_mask_next;
    logic                   shift_held_reg, shift_held_next;
    logic [7:0]             last_port_c_reg, last_port_c_next;
    logic                   port_a_input_reg, port_b_input_reg, port_c_low_input_reg;
    logic                   result_valid_reg;
    kmps_pkg::result_t      result_reg, result_next;
    kmps_pkg::key_update_t  key_update;
    logic [5:0]             rows_sensed;
    logic [11:0]            cols_sensed;
    logic                   cfg_write;

    assign busy      = 1'b0;
    assign cfg_ready = !req_valid_reg;
    assign cfg_write = cfg_valid && cfg_ready;

    // Register the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    kmps_matrix u_matrix
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_update  (key_update),
        .scan_mask   (scan_mask_reg),
        .sense_mask  (sense_mask_reg),
        .rows_sensed (rows_sensed),
        .cols_sensed (cols_sensed)
    );

    // Decode the registered request into state updates and the result
    always_comb
    begin
        logic [7:0] data;
        data             = req_reg.write_data;
        scan_mask_next   = scan_mask_reg;
        sense_mask_next  = sense_mask_reg;
        shift_held_next  = shift_held_reg;
        last_port_c_next = last_port_c_reg;
        result_next      = '0;
        key_update.en      = req_valid_reg && (req_reg.op == kmps_pkg::OP_KEY);
        key_update.row     = req_reg.key_row;
        key_update.col     = req_reg.key_column;
        key_update.pressed = req_reg.pressed;

        unique case (req_reg.op)
            kmps_pkg::OP_KEY:
            begin
            end
            kmps_pkg::OP_SHIFT:
            begin
                shift_held_next = req_reg.pressed;
            end
            kmps_pkg::OP_WRITE_A:
            begin
                if (port_a_input_reg)
                begin
                    data = 8'hFF;
                end
                scan_mask_next = {scan_mask_reg[11:8], data};
            end
            kmps_pkg::OP_WRITE_B:
            begin
                if (port_b_input_reg)
                begin
                    data = 8'hFF;
                end
                sense_mask_next = 6'((data & kmps_pkg::SENSE_FIELD_MASK) >> 2);
            end
            kmps_pkg::OP_WRITE_C:
            begin
                if (port_c_low_input_reg)
                begin
                    data = data | 8'h0F;
                end
                scan_mask_next = {data[3:0], scan_mask_reg[7:0]};
                last_port_c_next = data;
                result_next.port_c_written = 1'b1;
            end
            kmps_pkg::OP_READ_A:
            begin
                result_next.read_data = cols_sensed[7:0];
            end
            kmps_pkg::OP_READ_B:
            begin
                result_next.read_data = {rows_sensed, ~shift_held_reg, ~req_reg.tape_level};
            end
            kmps_pkg::OP_READ_C:
            begin
                result_next.read_data = {4'b0000, cols_sensed[11:8]};
            end
            default:
            begin
            end
        endcase

        result_next.sound_gate  = |(last_port_c_next & kmps_pkg::SOUND_BIT_MASK);
        result_next.tape_out    = |(last_port_c_next & kmps_pkg::TAPE_BIT_MASK);
        result_next.color_value = last_port_c_next & kmps_pkg::COLOR_MASK;
    end

    // Advance port state on a request; apply configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mask_reg        <= '1;
            sense_mask_reg       <= '1;
            shift_held_reg       <= 1'b0;
            last_port_c_reg      <= '0;
            port_a_input_reg     <= 1'b0;
            port_b_input_reg     <= 1'b0;
            port_c_low_input_reg <= 1'b0;
            result_valid_reg     <= 1'b0;
        end
        else
        begin
            result_valid_reg <= req_valid_reg;
            if (req_valid_reg)
            begin
                scan_mask_reg   <= scan_mask_next;
                sense_mask_reg  <= sense_mask_next;
                shift_held_reg  <= shift_held_next;
                last_port_c_reg <= last_port_c_next;
            end
            else if (cfg_write)
            begin
                priority if (cfg_index == kmps_pkg::CFG_PORT_A_INPUT)
                begin
                    port_a_input_reg <= cfg_data;
                    if (cfg_data)
                    begin
                        scan_mask_reg[7:0] <= 8'hFF;
                    end
                end
                else if (cfg_index == kmps_pkg::CFG_PORT_B_INPUT)
                begin
                    port_b_input_reg <= cfg_data;
                    if (cfg_data)
                    begin
                        sense_mask_reg <= '1;
                    end
                end
                else if (cfg_index == kmps_pkg::CFG_PORT_C_LOW_INPUT)
                begin
                    port_c_low_input_reg <= cfg_data;
                    if (cfg_data)
                    begin
                        scan_mask_reg <= scan_mask_reg | kmps_pkg::SCAN_HIGH_MASK;
                    end
                end
                else
                begin
                end
            end
        end
    end

    // Load the result register on each registered request; it holds until the next one
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every registered request yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |=> result_valid)
        else $error("registered request produced no result");

    // Colour output tracks the stored port C byte
    a_color_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.color_value == (last_port_c_reg & kmps_pkg::COLOR_MASK))
        else $error("color value does not match stored port C");

    // A port C write never returns read data
    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.port_c_written |-> result.read_data == 8'h00)
        else $error("port C write returned read data");

    // Switching port B to input mode releases all sense lines
    a_port_b_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && !req_valid_reg && cfg_index == kmps_pkg::CFG_PORT_B_INPUT && cfg_data
        |=> sense_mask_reg == 6'h3F)
        else $error("sense mask not released on port B input mode");

endmodule
